>>> hw/rtl/clipped_alpha_blend_blit_assert.svh
// Assertion macros for the clipped alpha-blend blitter checker.
`ifndef CLIPPED_ALPHA_BLEND_BLIT_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_BLIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CABB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cabb assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CABB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cabb assertion failed");

`endif

>>> hw/rtl/cabb_pkg.sv
// Package: constants, register codes and size clamps for the alpha-blend blitter.
`timescale 1ns / 1ps
`default_nettype none

package cabb_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int REG_W       = 13;
  localparam int COORD_W     = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int SRC_W       = 32;
  localparam int PIX_W       = 24;
  localparam int FIELD_LIMIT = 4096;
  localparam int FRAME_LIMIT = (MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT;
  localparam int REG_MAX     = (1 << REG_W) - 1;
  localparam int BMP_LIMIT   = (MAX_DIM < REG_MAX) ? MAX_DIM : REG_MAX;

  localparam logic [7:0] ALPHA_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLACE_X       = 3'd0,
    REG_PLACE_Y       = 3'd1,
    REG_BITMAP_WIDTH  = 3'd2,
    REG_BITMAP_HEIGHT = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5
  } cfg_reg_t;

  typedef logic [REG_W-1:0] reg_t;

  // zero counts as one, oversized counts as the limit
  function automatic reg_t bitmap_dim(input reg_t v);
    reg_t r;
    if (v == '0) begin
      r = reg_t'(1);
    end else if (v > reg_t'(BMP_LIMIT)) begin
      r = reg_t'(BMP_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic reg_t frame_dim(input reg_t v);
    reg_t r;
    if (v > reg_t'(FRAME_LIMIT)) begin
      r = reg_t'(FRAME_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/clipped_alpha_blend_blit.sv
// Pipeline: input stage, then result stage, both registered.
// Throughput: one item per cycle while out_stall is low; the blend stage and result register form the path.
// in_stall rises only when both stages hold items and out_stall is high.
// Reset (rst_n low, synchronous): both stages empty, counters at 0,
// place 0, bitmap 1 x 1, frame 0 x 0.
`timescale 1ns / 1ps
`default_nettype none

module clipped_alpha_blend_blit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_write_enable,
  input  wire logic [cabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cabb_pkg::REG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [cabb_pkg::SRC_W-1:0]      in_source_pixel,
  input  wire logic [cabb_pkg::PIX_W-1:0]      in_frame_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_write_enable,
  output logic [cabb_pkg::COORD_W-1:0]         out_target_x,
  output logic [cabb_pkg::COORD_W-1:0]         out_target_y,
  output logic [cabb_pkg::PIX_W-1:0]           out_blended_pixel,
  output logic                                 out_last_pixel
);
  import cabb_pkg::*;

  function automatic logic [7:0] blend_ch(input logic [7:0] d, input logic [7:0] s,
                                          input logic [7:0] a);
    logic [7:0]  inv;
    logic [15:0] n;
    logic [16:0] m;
    logic [17:0] q;
    inv = ALPHA_MAX - a;
    n   = 16'({8'd0, d} * {8'd0, inv}) + 16'({8'd0, s} * {8'd0, a});
    m   = {1'b0, n} + 17'd127;
    // exact floor(m / 255) for quotients up to 255
    q   = {1'b0, m} + 18'd1 + {9'd0, m[16:8]};
    return q[15:8];
  endfunction

  reg_t place_x_r, place_y_r, bmp_w_r, bmp_h_r, frm_w_r, frm_h_r;

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;

  logic               s1_valid_r;
  logic [SRC_W-1:0]   s1_src_r;
  logic [PIX_W-1:0]   s1_dst_r;
  logic               s1_inside_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic               s1_last_r;

  logic               out_valid_r;
  logic               out_we_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic               out_last_r;

  logic               adv, s1_ready, in_acc;
  reg_t               bw, bh, fw, fh;
  logic signed [REG_W:0] pos_x, pos_y;
  logic               in_frame, end_row, end_all;
  logic [PIX_W-1:0]   blend;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_x_r <= '0;
      place_y_r <= '0;
      bmp_w_r   <= reg_t'(1);
      bmp_h_r   <= reg_t'(1);
      frm_w_r   <= '0;
      frm_h_r   <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLACE_X:       place_x_r <= cfg_data;
        REG_PLACE_Y:       place_y_r <= cfg_data;
        REG_BITMAP_WIDTH:  bmp_w_r   <= cfg_data;
        REG_BITMAP_HEIGHT: bmp_h_r   <= cfg_data;
        REG_FRAME_WIDTH:   frm_w_r   <= cfg_data;
        REG_FRAME_HEIGHT:  frm_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign adv      = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || adv;
  assign in_stall = !s1_ready;
  assign in_acc   = in_valid && s1_ready;

  // placement and clipping
  always_comb begin
    bw       = bitmap_dim(bmp_w_r);
    bh       = bitmap_dim(bmp_h_r);
    fw       = frame_dim(frm_w_r);
    fh       = frame_dim(frm_h_r);
    pos_x    = $signed({place_x_r[REG_W-1], place_x_r}) + $signed({2'b00, col_r});
    pos_y    = $signed({place_y_r[REG_W-1], place_y_r}) + $signed({2'b00, row_r});
    in_frame = !pos_x[REG_W] && (pos_x[REG_W-1:0] < fw) &&
               !pos_y[REG_W] && (pos_y[REG_W-1:0] < fh);
    end_row  = {1'b0, col_r} >= (bw - reg_t'(1));
    end_all  = end_row && ({1'b0, row_r} >= (bh - reg_t'(1)));
    if (end_all) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (end_row) begin
      col_nxt = '0;
      row_nxt = row_r + COORD_W'(1);
    end else begin
      col_nxt = col_r + COORD_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r    <= in_source_pixel;
      s1_dst_r    <= in_frame_pixel;
      s1_inside_r <= in_frame;
      s1_x_r      <= pos_x[COORD_W-1:0];
      s1_y_r      <= pos_y[COORD_W-1:0];
      s1_last_r   <= end_all;
    end
  end

  // blend
  always_comb begin
    blend[23:16] = blend_ch(s1_dst_r[23:16], s1_src_r[23:16], s1_src_r[31:24]);
    blend[15:8]  = blend_ch(s1_dst_r[15:8],  s1_src_r[15:8],  s1_src_r[31:24]);
    blend[7:0]   = blend_ch(s1_dst_r[7:0],   s1_src_r[7:0],   s1_src_r[31:24]);
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_we_r   <= s1_inside_r;
      out_x_r    <= s1_inside_r ? s1_x_r : '0;
      out_y_r    <= s1_inside_r ? s1_y_r : '0;
      out_pix_r  <= s1_inside_r ? blend : '0;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_target_x      = out_x_r;
  assign out_target_y      = out_y_r;
  assign out_blended_pixel = out_pix_r;
  assign out_last_pixel    = out_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/cabb_checker.sv
// Port-level checker for the alpha-blend blitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "clipped_alpha_blend_blit_assert.svh"

module cabb_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            out_write_enable,
  input wire logic [cabb_pkg::COORD_W-1:0]    out_target_x,
  input wire logic [cabb_pkg::COORD_W-1:0]    out_target_y,
  input wire logic [cabb_pkg::PIX_W-1:0]      out_blended_pixel,
  input wire logic                            out_last_pixel
);
  import cabb_pkg::*;

  // clipped item carries zero coordinates and color
  `CABB_ASSERT_NOW(a_clip_zero, out_valid && !out_write_enable,
    out_target_x == '0 && out_target_y == '0 && out_blended_pixel == '0)

  // stalled result holds
  `CABB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_write_enable) && $stable(out_target_x) &&
    $stable(out_target_y) && $stable(out_blended_pixel) && $stable(out_last_pixel))

  // input backs up only behind a stalled result
  `CABB_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // pipeline empty right after reset
  `CABB_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid && !in_stall)

endmodule

bind clipped_alpha_blend_blit cabb_checker u_cabb_checker (.*);

`default_nettype wire
